[hw/rtl/mcd_pkg.sv]
// Shared types and constants for the monotone centred derivative block.
// No dependencies; imported by every module of the block.
package mcd_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam logic [IDX_W-1:0] COUNT_MAX = IDX_W'(MAX_POINTS - 1);

    // Configuration port
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LAST  = 1'b1;

    // Shared divider: 49-bit remainder, divisor and quotient
    localparam int DIV_W     = 49;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SLOPE  = 6'd49;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_WEIGHT = 6'd17;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FINAL  = 6'd32;

    // Weight L = 2^16 + r, with 3 * 2^16 as the full scale
    localparam int LW_W = 18;
    localparam logic [LW_W-1:0] LW_UNIT  = 18'd65536;
    localparam logic [LW_W-1:0] LW_EQUAL = 18'd98304;
    localparam logic [LW_W-1:0] LW_TOTAL = 18'd196608;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [30:0]        spacing;
        logic               end_of_sequence;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   point_index;
        logic signed [31:0] slope;
        logic               last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [IDX_W-1:0] window_first;
        logic [IDX_W-1:0] window_last;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     rem_init;
        logic [DIV_W-1:0]     num;
        logic [DIV_W-1:0]     den;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res;

endpackage

[hw/rtl/mcd_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on mcd_pkg.
module mcd_div import mcd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_num;
    logic [DIV_W-1:0]     r_den;
    logic [DIV_W-1:0]     r_quot;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] trial_sub;
    logic           fits;

    // Remainder stays below the divisor, so the trial value needs one extra bit
    always_comb begin
        trial     = {r_rem, r_num[DIV_W-1]};
        trial_sub = trial - {1'b0, r_den};
        fits      = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem_init;
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
            r_num  <= {r_num[DIV_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

[hw/rtl/mcd_core.sv]
// Sequencer and datapath: interval slope, weight and harmonic mean on one divider.
// Depends on mcd_pkg and mcd_div.
module mcd_core import mcd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_res     o_res,
    input  logic     i_res_ready
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_SLOPE_LD   = 4'd1;
    localparam logic [3:0] S_SLOPE_WAIT = 4'd2;
    localparam logic [3:0] S_SIGN       = 4'd3;
    localparam logic [3:0] S_WGT_WAIT   = 4'd4;
    localparam logic [3:0] S_MUL_AB     = 4'd5;
    localparam logic [3:0] S_MUL_LB     = 4'd6;
    localparam logic [3:0] S_MUL_LA     = 4'd7;
    localparam logic [3:0] S_FIN_LD     = 4'd8;
    localparam logic [3:0] S_FIN_WAIT   = 4'd9;
    localparam logic [3:0] S_EMIT0      = 4'd10;
    localparam logic [3:0] S_EMIT1      = 4'd11;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // Signed result from a quotient magnitude, clamped to 32 bits
    function automatic logic [31:0] sat_quot(input logic neg, input logic [DIV_W-1:0] q);
        logic [31:0] res;
        if (neg) begin
            res = (q > DIV_W'(33'h080000000)) ? 32'h80000000 : (~q[31:0] + 32'd1);
        end else begin
            res = (q > DIV_W'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
        end
        return res;
    endfunction

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_count;
    logic [31:0]      r_prior_value;
    logic [30:0]      r_prior_spacing;
    logic [31:0]      r_prior_slope;

    t_in_item         r_cur;
    logic [31:0]      r_der;
    logic [31:0]      r_res0;
    logic             r_neg;
    logic [31:0]      r_a;
    logic [31:0]      r_b;
    logic [LW_W-1:0]  r_lw;
    logic [63:0]      r_prod;
    logic [63:0]      r_num;
    logic [DIV_W-1:0] r_den;

    t_div_req         div_req;
    t_div_rsp         div_rsp;

    logic [32:0]      val_diff;
    logic [32:0]      diff_mag;
    logic             both_pos;
    logic             both_neg;
    logic [31:0]      span;
    logic [IDX_W-1:0] idx0;
    logic             emit0;
    logic             emit1;
    logic             run_done;
    logic [31:0]      mul_x;
    logic [31:0]      mul_y;
    logic [63:0]      mul_p;

    mcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        val_diff = {r_cur.sample_value[31], r_cur.sample_value}
                 - {r_prior_value[31], r_prior_value};
        diff_mag = val_diff[32] ? (~val_diff + 33'd1) : val_diff;
        both_pos = !r_prior_slope[31] && (r_prior_slope != '0)
                && !r_der[31] && (r_der != '0);
        both_neg = r_prior_slope[31] && r_der[31];
        span     = {1'b0, r_prior_spacing} + {1'b0, r_cur.spacing};
        idx0     = (r_count == IDX_W'(1)) ? '0 : (r_count - IDX_W'(1));
        emit0    = (idx0 >= i_cfg.window_first) && (idx0 <= i_cfg.window_last);
        emit1    = r_cur.end_of_sequence
                && (r_count >= i_cfg.window_first) && (r_count <= i_cfg.window_last);
        run_done = (r_state == S_EMIT1) && (!emit1 || i_res_ready);
    end

    // One multiplier, operands picked by step
    always_comb begin
        case (r_state)
            S_MUL_LB: begin
                mul_x = {14'd0, r_lw};
                mul_y = r_b;
            end
            S_MUL_LA: begin
                mul_x = {14'd0, LW_TOTAL - r_lw};
                mul_y = r_a;
            end
            default: begin
                mul_x = r_a;
                mul_y = r_b;
            end
        endcase
        mul_p = mul_x * mul_y;
    end

    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.rem_init = '0;
        div_req.num      = {diff_mag, 16'd0};
        div_req.den      = DIV_W'(r_cur.spacing);
        div_req.steps    = DIV_STEPS_SLOPE;
        o_res.valid      = 1'b0;
        o_res.item.point_index = idx0;
        o_res.item.slope       = r_res0;
        o_res.item.last_of_run = !emit1;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && (r_count != '0)) begin
                    n_state = S_SLOPE_LD;
                end
            end
            S_SLOPE_LD: begin
                if (r_cur.spacing == '0) begin
                    n_state = S_SIGN;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_SLOPE_WAIT;
                end
            end
            S_SLOPE_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                // quotient below 2^17, so the top bits of hR*2^16 preload the remainder
                div_req.rem_init = DIV_W'(r_cur.spacing[30:1]);
                div_req.num      = {r_cur.spacing[0], (DIV_W-1)'(0)};
                div_req.den      = DIV_W'(span);
                div_req.steps    = DIV_STEPS_WEIGHT;
                if ((r_count == IDX_W'(1)) || !(both_pos || both_neg)) begin
                    n_state = S_EMIT0;
                end else if (span == '0) begin
                    n_state = S_MUL_AB;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_WGT_WAIT;
                end
            end
            S_WGT_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_MUL_AB;
                end
            end
            S_MUL_AB: n_state = S_MUL_LB;
            S_MUL_LB: n_state = S_MUL_LA;
            S_MUL_LA: n_state = S_FIN_LD;
            S_FIN_LD: begin
                // quotient below 2^32: n/2^16 preloads the remainder
                div_req.start    = 1'b1;
                div_req.rem_init = DIV_W'(r_num[63:16]);
                div_req.num      = {r_num[15:0], 33'd0};
                div_req.den      = r_den;
                div_req.steps    = DIV_STEPS_FINAL;
                n_state          = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_EMIT0;
                end
            end
            S_EMIT0: begin
                o_res.valid = emit0;
                if (!emit0 || i_res_ready) begin
                    n_state = S_EMIT1;
                end
            end
            S_EMIT1: begin
                o_res.valid            = emit1;
                o_res.item.point_index = r_count;
                o_res.item.slope       = r_der;
                o_res.item.last_of_run = 1'b1;
                if (run_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    // Control and carried sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_prior_value   <= '0;
            r_prior_spacing <= '0;
            r_prior_slope   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_IDLE) && i_valid && (r_count == '0)) begin
                r_prior_value   <= i_item.sample_value;
                r_prior_spacing <= i_item.spacing;
                r_prior_slope   <= '0;
                r_count         <= i_item.end_of_sequence ? '0 : IDX_W'(1);
            end else if (run_done) begin
                r_prior_value   <= r_cur.sample_value;
                r_prior_spacing <= r_cur.spacing;
                r_prior_slope   <= r_der;
                if (r_cur.end_of_sequence) begin
                    r_count <= '0;
                end else if (r_count != COUNT_MAX) begin
                    r_count <= r_count + IDX_W'(1);
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cur <= i_item;
            end
            S_SLOPE_LD: begin
                r_neg <= val_diff[32];
                if (val_diff[32]) begin
                    r_der <= 32'h80000000;
                end else if (val_diff != '0) begin
                    r_der <= 32'h7FFFFFFF;
                end else begin
                    r_der <= '0;
                end
            end
            S_SLOPE_WAIT: begin
                if (div_rsp.done) begin
                    r_der <= sat_quot(r_neg, div_rsp.quot);
                end
            end
            S_SIGN: begin
                r_a   <= mag32(r_prior_slope);
                r_b   <= mag32(r_der);
                r_neg <= both_neg;
                r_lw  <= LW_EQUAL;
                if (r_count == IDX_W'(1)) begin
                    r_res0 <= r_der;
                end else begin
                    r_res0 <= '0;
                end
            end
            S_WGT_WAIT: begin
                if (div_rsp.done) begin
                    r_lw <= LW_UNIT + LW_W'(div_rsp.quot[16:0]);
                end
            end
            S_MUL_AB: begin
                r_prod <= mul_p;
            end
            S_MUL_LB: begin
                r_num <= {r_prod[62:0], 1'b0} + r_prod;
                r_den <= mul_p[DIV_W-1:0];
            end
            S_MUL_LA: begin
                r_den <= r_den + mul_p[DIV_W-1:0];
            end
            S_FIN_WAIT: begin
                if (div_rsp.done) begin
                    r_res0 <= sat_quot(r_neg, div_rsp.quot);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[hw/rtl/monotone_centered_derivative.sv]
// Top level of the monotone centred derivative block: configuration registers,
// result output register and checks. Depends on mcd_pkg and mcd_core.

// Takes a stream of samples (signed Q16.16 value, unsigned Q15.16 spacing from the previous
// sample, end-of-sequence flag) and returns the derivative at each point, limited to
// the point indices in [window_first, window_last]. Interior points get the
// Fritsch-Butland weighted harmonic mean of the two neighbouring interval slopes,
// zero where the slopes disagree in sign or one is zero; the end points take their
// one-sided slope. A point's result is known once the next sample is in, so an item
// yields up to two results (the previous point, and the current one when it ends the
// sequence); last_of_run marks the final result of an item. The first sample of a
// sequence is only stored, and input ready stays high. Every other sample runs its
// interval slope through the single radix-2 divider (49 quotient steps, skipped
// when the spacing is zero); where the slopes agree in sign the weight division
// (17 steps), three multiplier steps and the final division (32 steps) follow on
// the same divider. Input ready is low from accept until the item's results have
// gone into the output register, including any wait for room there. The last result
// of an item sits in the output register, so the next item can be taken while it
// waits. Configuration writes take effect at once and belong in idle periods.
module monotone_centered_derivative import mcd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_res      core_res;
    logic      res_ready;

    // Output register is free, or emptying this cycle
    assign res_ready = !r_out_valid || i_ready;

    mcd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .o_res       (core_res),
        .i_res_ready (res_ready)
    );

    // Window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_first <= '0;
            r_cfg.window_last  <= COUNT_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WINDOW_FIRST: r_cfg.window_first <= i_cfg_data;
                REG_WINDOW_LAST:  r_cfg.window_last  <= i_cfg_data;
            endcase
        end
    end

    // Result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= core_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && core_res.valid) begin
            r_out_item <= core_res.item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // The core only offers results while it holds an item
    a_res_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_res.valid |-> !o_ready)
        else $error("result offered while input side ready");

    // Nothing leaves outside the window
    a_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.point_index >= r_cfg.window_first)
                 && (o_item.point_index <= r_cfg.window_last))
        else $error("result outside configured window");

    // A non-final result means the item's second result is still pending
    a_pending_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.last_of_run) |-> !o_ready)
        else $error("input ready while the run is incomplete");

    // A freshly accepted item cannot produce a result on the next cycle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !core_res.valid)
        else $error("result straight after accept");

endmodule

[tb/mcd_derivative_checker.sv]
// Checker for the monotone centred derivative block: watches both item channels
// and the configuration port, predicts each derivative and compares it on arrival.
// Depends on mcd_pkg for the item types, register indexes and the point limit.
module mcd_derivative_checker import mcd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    t_out_item derivs_due[$];

    logic [IDX_W-1:0]   win_lo;
    logic [IDX_W-1:0]   win_hi;
    logic [IDX_W-1:0]   next_point;
    logic signed [31:0] last_value;
    logic signed [31:0] last_slope;
    logic [30:0]        last_spacing;

    // Interval slope in Q16.16, truncated toward zero and saturated
    function automatic logic signed [31:0] secant_slope(input logic signed [31:0] from_v,
                                                        input logic signed [31:0] to_v,
                                                        input logic [30:0] dx);
        longint rise;
        longint q;
        rise = longint'(to_v) - longint'(from_v);
        if (dx == '0) begin
            if (rise > 0) return 32'sh7fff_ffff;
            if (rise < 0) return 32'sh8000_0000;
            return '0;
        end
        q = (rise * 64'sd65536) / longint'(dx);
        if (q > 64'sd2147483647) return 32'sh7fff_ffff;
        if (q < -64'sd2147483648) return 32'sh8000_0000;
        return 32'(q);
    endfunction

    // Weighted harmonic mean of two slopes; zero unless they share a sign
    function automatic logic signed [31:0] harmonic_blend(input logic signed [31:0] sl,
                                                          input logic signed [31:0] sr,
                                                          input logic [30:0] hl,
                                                          input logic [30:0] hr);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] lw;
        logic [63:0] d;
        logic [95:0] q;
        if (!((sl > 0 && sr > 0) || (sl < 0 && sr < 0))) return '0;
        a  = (sl < 0) ? 64'(-longint'(sl)) : 64'(longint'(sl));
        b  = (sr < 0) ? 64'(-longint'(sr)) : 64'(longint'(sr));
        s  = 64'(hl) + 64'(hr);
        r  = (s != 0) ? (64'(hr) << 16) / s : 64'd32768;
        lw = 64'd65536 + r;
        d  = lw * b + (64'd196608 - lw) * a;
        q  = ((96'(a) * 96'(b) * 96'd3) << 16) / 96'(d);
        if (sl > 0) return (q > 96'd2147483647) ? 32'sh7fff_ffff : 32'(q);
        return (q > 96'd2147483648) ? 32'sh8000_0000 : -(32'(q));
    endfunction

    function automatic bit in_window(input logic [IDX_W-1:0] idx);
        return idx >= win_lo && idx <= win_hi;
    endfunction

    task automatic predict_step(input t_in_item it);
        t_out_item          got [2];
        int                 n;
        logic signed [31:0] fresh;
        logic signed [31:0] inner;
        logic [IDX_W-1:0]   inner_idx;
        n = 0;
        if (next_point == '0) begin
            last_value   = it.sample_value;
            last_spacing = it.spacing;
            last_slope   = '0;
            next_point   = it.end_of_sequence ? '0 : IDX_W'(1);
            return;
        end
        fresh     = secant_slope(last_value, it.sample_value, it.spacing);
        inner_idx = next_point - IDX_W'(1);
        inner     = (next_point == IDX_W'(1)) ? fresh
                  : harmonic_blend(last_slope, fresh, last_spacing, it.spacing);
        if (in_window(inner_idx)) begin
            got[n] = '{inner_idx, inner, 1'b0};
            n++;
        end
        if (it.end_of_sequence && in_window(next_point)) begin
            got[n] = '{next_point, fresh, 1'b0};
            n++;
        end
        if (n > 0) got[n-1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++) derivs_due.insert(derivs_due.size(), got[k]);
        last_value   = it.sample_value;
        last_spacing = it.spacing;
        last_slope   = fresh;
        if (it.end_of_sequence) next_point = '0;
        else if (next_point < COUNT_MAX) next_point = next_point + IDX_W'(1);
    endtask

    task automatic note_mismatch(input string what, input longint want_v, input longint got_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            derivs_due.delete();
            win_lo       = '0;
            win_hi       = '1;
            next_point   = '0;
            last_value   = '0;
            last_slope   = '0;
            last_spacing = '0;
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // results first: a result never belongs to an item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (derivs_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got point %0d slope %0d",
                             $time, i_out_item.point_index, i_out_item.slope);
                    o_fail_count++;
                end else begin
                    want = derivs_due.pop_front();
                    o_checked++;
                    if (i_out_item.point_index != want.point_index)
                        note_mismatch("point_index", want.point_index, i_out_item.point_index);
                    if (i_out_item.slope != want.slope)
                        note_mismatch("slope", want.slope, i_out_item.slope);
                    if (i_out_item.last_of_run != want.last_of_run)
                        note_mismatch("last_of_run", want.last_of_run, i_out_item.last_of_run);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WINDOW_FIRST: win_lo = i_cfg_data[IDX_W-1:0];
                    REG_WINDOW_LAST:  win_hi = i_cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_step(i_in_item);
        end
        o_pending = derivs_due.size();
    end

endmodule

[tb/monotone_centered_derivative_test.sv]
// Top of the testbench for monotone_centered_derivative: clock, reset, sample
// stimulus, output back-pressure, window writes, watchdog and verdict.
// Depends on mcd_pkg, the block itself and mcd_derivative_checker.
module monotone_centered_derivative_test import mcd_pkg::*;;

    localparam int STALL_LIMIT = 4000;  // cycles with no item moving on either side
    localparam int HOLD_OFF    = 800;   // long receiver hold-off, in cycles
    localparam int SETTLE      = 300;   // quiet time before a window write / the verdict
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 30;    // random items per ordinary phase
    localparam int LONG_RUN    = 1030;  // one sequence past the point limit

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int checked;
    int sent;
    int quiet_cycles;

    bit steady;    // no idling on either side while set
    bit hold_req;  // asks the receiver for its one long hold-off

    logic signed [31:0] walk_value;
    int                 walk_dir;

    // Per-phase window and behaviour; extremes, a single point, an inverted
    // window and one long sequence near the top of the index range
    logic [9:0] win_lo_tab [PHASES] = '{0, 3,  0, 1023, 1023, 5, 1,    1020, 0};
    logic [9:0] win_hi_tab [PHASES] = '{1023, 9, 0, 0, 1023, 5, 1022, 1023, 1023};
    bit steady_tab [PHASES] = '{0, 0, 1, 0, 0, 0, 0, 0, 1};
    bit hold_tab   [PHASES] = '{1, 0, 0, 0, 0, 0, 0, 0, 0};
    bit long_tab   [PHASES] = '{0, 0, 0, 0, 0, 0, 0, 1, 0};

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    monotone_centered_derivative u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_item      (in_item),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_item      (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mcd_derivative_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Idle length shared by both sides: mostly none or short, now and then long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(99);
        if (steady || roll < 50) return 0;
        if (roll < 82) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Next sample value: mostly a monotone walk so that the blend path is hit,
    // with flats, turning points, full-range jumps and the value extremes
    function automatic logic signed [31:0] next_value();
        int roll;
        int step;
        roll = $urandom_range(99);
        step = int'($urandom_range(1, 32'h0010_0000));
        if (roll < 45) begin
            walk_value = walk_value + ((walk_dir < 0) ? -step : step);
        end else if (roll < 55) begin
            // flat: zero difference
        end else if (roll < 63) begin
            walk_dir   = -walk_dir;
            walk_value = walk_value + ((walk_dir < 0) ? -step : step);
        end else if (roll < 78) begin
            walk_value = $urandom;
        end else if (roll < 88) begin
            case ($urandom_range(3))
                0:       walk_value = 32'sh7fff_ffff;
                1:       walk_value = 32'sh8000_0000;
                2:       walk_value = '0;
                default: walk_value = -32'sd1;
            endcase
        end else begin
            walk_value = walk_value + int'($urandom_range(64)) - 32;
        end
        return walk_value;
    endfunction

    // Spacing: typical unsigned Q15.16 distances, plus zero, one, full scale and noise
    function automatic logic [30:0] next_spacing();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return 31'($urandom_range(32'h0000_1000, 32'h0004_0000));
        if (roll < 62) return 31'($urandom);
        if (roll < 70) return 31'd1;
        if (roll < 75) return '0;
        if (roll < 83) return 31'h7fff_ffff;
        if (roll < 93) return 31'($urandom_range(1, 255));
        return 31'($urandom_range(32'h0004_0000, 32'h0100_0000));
    endfunction

    function automatic int seq_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return 1;
        if (roll < 20) return 2;
        if (roll < 80) return $urandom_range(3, 12);
        return $urandom_range(13, 40);
    endfunction

    // Offers one item and returns at the falling edge after it is taken.
    // Valid stays high into the next item when no gap is drawn.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge clk); while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_fixed(input logic signed [31:0] v, input logic [30:0] sp,
                              input logic eos);
        t_in_item it;
        it.sample_value    = v;
        it.spacing         = sp;
        it.end_of_sequence = eos;
        send_item(it);
    endtask

    task automatic send_sequence(input int len);
        walk_dir = $urandom_range(1) ? 1 : -1;
        if ($urandom_range(3) == 0) walk_value = $urandom;
        for (int i = 0; i < len; i++) send_fixed(next_value(), next_spacing(), i == len - 1);
    endtask

    // Block idle: nothing owed, plus time for an item that owes no result
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_window(input logic [9:0] lo, input logic [9:0] hi);
        cfg_we    = 1'b1;
        cfg_index = REG_WINDOW_FIRST;
        cfg_data  = lo;
        @(negedge clk);
        cfg_index = REG_WINDOW_LAST;
        cfg_data  = hi;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Receiver: random ready, or one long hold-off on request while the
    // sender keeps offering items, so the block backs up into its input
    initial begin : receiver
        int gap;
        bit held;
        out_ready = 1'b0;
        held      = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !held) begin
                held      = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
            end else begin
                gap = ($urandom_range(3) != 0) ? 0 : idle_len();
                out_ready = (gap == 0);
                if (gap > 1) repeat (gap - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int target;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_WINDOW_FIRST;
        cfg_data   = '0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        sent       = 0;
        walk_value = '0;
        walk_dir   = 1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset window
        // a lone sample gives nothing
        send_fixed(32'sh0005_0000, 31'h7fff_ffff, 1'b1);
        // two points: both ends one-sided
        send_fixed(32'sh0000_0000, 31'h0000_0000, 1'b0);
        send_fixed(32'sh0001_0000, 31'h0001_0000, 1'b1);
        // rise with unequal spacings, flat, fall, sign change into saturated slopes
        send_fixed(32'sh0000_0000, 31'd123,        1'b0);
        send_fixed(32'sh0002_0000, 31'h0001_0000, 1'b0);
        send_fixed(32'sh0003_0000, 31'h0003_0000, 1'b0);
        send_fixed(32'sh0003_0000, 31'h0001_0000, 1'b0);
        send_fixed(32'sh0001_0000, 31'h0002_0000, 1'b0);
        send_fixed(32'shfffc_0000, 31'h0000_8000, 1'b0);
        send_fixed(32'sh7fff_ffff, 31'd1,         1'b0);
        send_fixed(32'sh8000_0000, 31'd1,         1'b1);
        // zero spacings: saturate up, both spacings zero, zero over zero, saturate down
        send_fixed(32'sd0,  31'd0, 1'b0);
        send_fixed(32'sd10, 31'd0, 1'b0);
        send_fixed(32'sd20, 31'd0, 1'b0);
        send_fixed(32'sd20, 31'd0, 1'b0);
        send_fixed(32'sd5,  31'd0, 1'b1);
        // full-scale values and spacings
        send_fixed(32'sh8000_0000, 31'h7fff_ffff, 1'b0);
        send_fixed(32'sh7fff_ffff, 31'h7fff_ffff, 1'b0);
        send_fixed(32'sh7fff_ffff, 31'd1,         1'b0);
        send_fixed(32'sh0000_0000, 31'h7fff_ffff, 1'b1);

        // Random part, one window setting per phase
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_window(win_lo_tab[p], win_hi_tab[p]);
            steady   = steady_tab[p];
            hold_req = hold_tab[p];
            if (long_tab[p]) begin
                send_sequence(LONG_RUN);
            end else begin
                target = sent + PHASE_ITEMS;
                while (sent < target) send_sequence(seq_len());
            end
        end
        settle();

        $display("%0d sample items over %0d window settings, %0d derivatives checked",
                 sent, PHASES, checked);
        $display("covered: lone samples, zero spacings, saturation, a run past the point limit"
                 , " and a long output hold-off");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mcd_pkg.sv
hw/rtl/mcd_div.sv
hw/rtl/mcd_core.sv
hw/rtl/monotone_centered_derivative.sv
tb/mcd_derivative_checker.sv
tb/monotone_centered_derivative_test.sv
